>>> hdl/oafr_pkg.sv
// Shared types and constants of the overwriting audio frame ring.
// No dependencies; oafr_if, the top level and the bench refer to this package.
`default_nettype none

package oafr_pkg;

  localparam int SAMPLE_W      = 32;
  localparam int FRAME_W       = 2 * SAMPLE_W;
  localparam int FCOUNT_W      = 7;
  localparam int CAP_W         = 11;
  localparam int TOTAL_W       = 64;
  localparam int EVENT_W       = 32;

  localparam int DEPTH_DEFAULT     = 1024;
  localparam int CHANNELS_DEFAULT  = 2;
  localparam int MAX_BURST_DEFAULT = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TAP   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_EMIT,
    S_REMAP,
    S_WIPE
  } state_t;

  typedef struct packed {
    op_t                 operation;
    logic [SAMPLE_W-1:0] sample_in_0;
    logic [SAMPLE_W-1:0] sample_in_1;
    logic [FCOUNT_W-1:0] frame_count;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_out_0;
    logic [SAMPLE_W-1:0] sample_out_1;
    logic                from_buffer;
    logic                last_frame;
    logic [TOTAL_W-1:0]  written_frames;
    logic [TOTAL_W-1:0]  read_frames;
    logic [EVENT_W-1:0]  underrun_events;
    logic [EVENT_W-1:0]  overrun_frames;
  } out_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] written;
    logic [TOTAL_W-1:0] read;
    logic [EVENT_W-1:0] underrun;
    logic [EVENT_W-1:0] overrun;
  } totals_t;

endpackage

`default_nettype wire

>>> hdl/oafr_if.sv
// Valid/ready channel interfaces: request items, result items, capacity writes.
// Depends on oafr_pkg for the payload types.
`default_nettype none

interface oafr_in_if;
  logic                 valid;
  logic                 ready;
  oafr_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface oafr_out_if;
  logic                 valid;
  logic                 ready;
  oafr_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface oafr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [oafr_pkg::CAP_W-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/oafr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module oafr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/oafr_mod.sv
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// No dependencies; the divisor must stay stable while busy.
`default_nettype none

module oafr_mod #(
  parameter int DW = 64,
  parameter int CW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic          busy,
  output logic [CW-1:0] remainder
);

  localparam int NW = $clog2(DW + 1);

  logic [DW-1:0] shreg;
  logic [NW-1:0] steps;
  logic [CW:0]   trial;
  logic [CW-1:0] rem_next;

  // partial remainder stays below the divisor, so trial < 2*divisor
  always_comb begin
    trial = {remainder, shreg[DW-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = CW'(trial - {1'b0, divisor});
    end else begin
      rem_next = CW'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && steps == NW'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= dividend;
      remainder <= '0;
      steps     <= NW'(DW);
    end else if (busy) begin
      shreg     <= shreg << 1;
      remainder <= rem_next;
      steps     <= steps - NW'(1);
    end
  end

endmodule

`default_nettype wire

>>> hdl/overwriting_audio_frame_ring.sv
// Overwriting audio frame ring, top level.
// Depends on oafr_pkg, oafr_if, oafr_ram and oafr_mod.
`default_nettype none

// Frames live in one RAM with a registered read port; positions, totals and the
// unread count sit in registers. An accepted item is planned first (totals,
// slots and, for a write, the RAM write) and then emits its results at up to
// one per cycle, while there is room, into a two-entry result queue; the next
// item is taken in the cycle of the last result. A clear also wipes the store
// to zero, one entry per cycle. A capacity write re-derives both slots as
// totals mod capacity with a bit-serial remainder unit, and no item is accepted
// until it is done. Store contents are undefined after reset until written or
// cleared.
module overwriting_audio_frame_ring #(
  parameter int DEPTH     = oafr_pkg::DEPTH_DEFAULT,
  parameter int CHANNELS  = oafr_pkg::CHANNELS_DEFAULT,
  parameter int MAX_BURST = oafr_pkg::MAX_BURST_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  oafr_in_if.sink     in_ch,
  oafr_out_if.source  out_ch,
  oafr_cfg_if.sink    cfg
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int BW = $clog2(MAX_BURST + 1);
  localparam int SW = ((CW > BW) ? CW : BW) + 1;
  localparam int FW = oafr_pkg::SAMPLE_W * CHANNELS;
  localparam int TW = oafr_pkg::TOTAL_W;
  localparam int EW = oafr_pkg::EVENT_W;
  localparam int XW = oafr_pkg::FRAME_W;

  oafr_pkg::state_t state, state_next;

  logic [oafr_pkg::CAP_W-1:0] cap_reg;
  logic [CW-1:0]              eff_cap;

  logic [AW-1:0] write_slot, read_slot;
  logic [TW-1:0] write_total, read_total, pend;
  logic [EW-1:0] underrun_total, overrun_total;

  oafr_pkg::op_t  op_q;
  logic [FW-1:0]  frame_q;
  logic [BW-1:0]  n_q;

  logic [BW-1:0] em_cnt, em_copy, em_k;
  logic [AW-1:0] em_addr;
  logic          em_last, em_from;
  logic [AW-1:0] em_addr_inc;

  logic               s1_valid, s1_from, s1_last;
  oafr_pkg::totals_t  s1_tot;

  oafr_pkg::out_item_t fifo [2];
  logic                wr_ptr, rd_ptr;
  logic [1:0]          count;
  logic                pop;
  oafr_pkg::out_item_t push_item;

  logic          in_ready, cfg_ready, in_accept, cfg_accept;
  logic          issue, credit_ok, mod_start, mod_busy;
  logic          w_busy, r_busy;
  logic [CW-1:0] w_rem, r_rem;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, wipe_addr;
  logic [FW-1:0] ram_wdata;
  logic [FW-1:0] ram_rdata;
  logic [XW-1:0] rd_wide, frame_wide;
  logic [BW-1:0] n_sat;

  // plan results
  logic          pend_ge_cap, catch_up;
  logic [AW-1:0] ws_inc;
  logic [TW-1:0] wr_rt, avail_r, avail_t, rt_final_r, pend_final_r;
  logic [EW-1:0] ovr_add;
  logic [BW-1:0] copy_r, copy_t, copy_sel;
  logic [AW-1:0] start_r, start_t, start_sel, rslot_final;
  logic [SW-1:0] rsum;

  // capacity clamp: zero acts as one, above the store depth as the depth
  always_comb begin
    if (cap_reg == '0) begin
      eff_cap = CW'(1);
    end else if (32'(cap_reg) > 32'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(cap_reg);
    end
  end

  assign frame_wide = {in_ch.data.sample_in_1, in_ch.data.sample_in_0};
  assign n_sat = (32'(in_ch.data.frame_count) > 32'(MAX_BURST)) ?
                 BW'(MAX_BURST) : BW'(in_ch.data.frame_count);

  // ---------------- plan ----------------
  always_comb begin
    pend_ge_cap = pend >= TW'(eff_cap);
    ws_inc      = (SW'(write_slot) + SW'(1) == SW'(eff_cap)) ? '0 : write_slot + AW'(1);
    wr_rt       = write_total - TW'(eff_cap - CW'(1));
    ovr_add     = EW'(pend) + EW'(1) - EW'(eff_cap);

    // read: fall back to the newest capacity frames when too far behind
    catch_up     = pend > TW'(eff_cap);
    avail_r      = catch_up ? TW'(eff_cap) : pend;
    copy_r       = (avail_r > TW'(n_q)) ? n_q : BW'(avail_r);
    start_r      = catch_up ? write_slot : read_slot;
    rt_final_r   = catch_up ? write_total - TW'(SW'(eff_cap) - SW'(copy_r))
                            : read_total + TW'(copy_r);
    pend_final_r = avail_r - TW'(copy_r);
    rsum         = SW'(start_r) + SW'(copy_r);
    rslot_final  = (rsum >= SW'(eff_cap)) ? AW'(rsum - SW'(eff_cap)) : AW'(rsum);

    // tap: newest frames, oldest first
    avail_t = (write_total < TW'(eff_cap)) ? write_total : TW'(eff_cap);
    copy_t  = (avail_t > TW'(n_q)) ? n_q : BW'(avail_t);
    if (SW'(write_slot) >= SW'(copy_t)) begin
      start_t = AW'(SW'(write_slot) - SW'(copy_t));
    end else begin
      start_t = AW'(SW'(write_slot) + SW'(eff_cap) - SW'(copy_t));
    end

    copy_sel  = (op_q == oafr_pkg::OP_READ) ? copy_r : copy_t;
    start_sel = (op_q == oafr_pkg::OP_READ) ? start_r : start_t;
  end

  // ---------------- emit ----------------
  assign pop       = out_ch.valid && out_ch.ready;
  assign credit_ok = (3'(count) + 3'(s1_valid)) < (3'd2 + 3'(pop));
  assign em_last   = em_k == em_cnt - BW'(1);
  assign em_from   = em_k < em_copy;
  assign em_addr_inc = (SW'(em_addr) + SW'(1) == SW'(eff_cap)) ? '0 : em_addr + AW'(1);

  // ---------------- control ----------------
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    issue      = 1'b0;
    mod_start  = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    case (state)
      oafr_pkg::S_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg.valid;
        if (cfg.valid) begin
          mod_start  = 1'b1;
          state_next = oafr_pkg::S_REMAP;
        end else if (in_ch.valid) begin
          state_next = oafr_pkg::S_PLAN;
        end
      end
      oafr_pkg::S_PLAN: begin
        ram_we = op_q == oafr_pkg::OP_WRITE;
        if (op_q == oafr_pkg::OP_CLEAR) begin
          state_next = oafr_pkg::S_WIPE;
        end else begin
          state_next = oafr_pkg::S_EMIT;
        end
      end
      // zero every store entry, then emit the status result
      oafr_pkg::S_WIPE: begin
        ram_we = 1'b1;
        if (wipe_addr == AW'(DEPTH - 1)) begin
          state_next = oafr_pkg::S_EMIT;
        end
      end
      oafr_pkg::S_EMIT: begin
        issue  = credit_ok;
        ram_re = credit_ok && em_from;
        if (credit_ok && em_last) begin
          in_ready   = 1'b1;
          state_next = in_ch.valid ? oafr_pkg::S_PLAN : oafr_pkg::S_IDLE;
        end
      end
      oafr_pkg::S_REMAP: begin
        cfg_ready = 1'b1;
        if (cfg.valid) begin
          mod_start = 1'b1;
        end else if (!mod_busy) begin
          state_next = oafr_pkg::S_IDLE;
        end
      end
      default: state_next = oafr_pkg::S_IDLE;
    endcase
  end

  assign in_accept   = in_ch.valid && in_ready;
  assign cfg_accept  = cfg.valid && cfg_ready;
  assign in_ch.ready = in_ready;
  assign cfg.ready   = cfg_ready;
  assign mod_busy    = w_busy || r_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oafr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- state registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg        <= oafr_pkg::CAP_RESET;
      write_slot     <= '0;
      read_slot      <= '0;
      write_total    <= '0;
      read_total     <= '0;
      pend           <= '0;
      underrun_total <= '0;
      overrun_total  <= '0;
      em_cnt         <= '0;
      em_copy        <= '0;
      em_k           <= '0;
      em_addr        <= '0;
      wipe_addr      <= '0;
      s1_valid       <= 1'b0;
    end else begin
      if (cfg_accept) begin
        cap_reg <= cfg.data;
      end

      if (state == oafr_pkg::S_REMAP && !cfg.valid && !mod_busy) begin
        write_slot <= AW'(w_rem);
        read_slot  <= AW'(r_rem);
      end

      if (state == oafr_pkg::S_WIPE) begin
        wipe_addr <= wipe_addr + AW'(1);
      end

      if (state == oafr_pkg::S_PLAN) begin
        em_k      <= '0;
        em_cnt    <= BW'(1);
        em_copy   <= '0;
        em_addr   <= start_sel;
        wipe_addr <= '0;
        case (op_q)
          oafr_pkg::OP_WRITE: begin
            write_slot  <= ws_inc;
            write_total <= write_total + TW'(1);
            if (pend_ge_cap) begin
              overrun_total <= overrun_total + ovr_add;
              read_total    <= wr_rt;
              read_slot     <= ws_inc;
              pend          <= TW'(eff_cap);
            end else begin
              pend <= pend + TW'(1);
            end
          end
          oafr_pkg::OP_CLEAR: begin
            write_slot     <= '0;
            read_slot      <= '0;
            write_total    <= '0;
            read_total     <= '0;
            pend           <= '0;
            underrun_total <= '0;
            overrun_total  <= '0;
          end
          oafr_pkg::OP_READ, oafr_pkg::OP_TAP: begin
            if (n_q != '0) begin
              em_cnt  <= n_q;
              em_copy <= copy_sel;
              if (copy_sel < n_q) begin
                underrun_total <= underrun_total + EW'(1);
              end
              if (op_q == oafr_pkg::OP_READ) begin
                read_total <= rt_final_r;
                pend       <= pend_final_r;
                read_slot  <= rslot_final;
              end
            end
          end
          default: ;
        endcase
      end

      if (issue) begin
        em_k <= em_k + BW'(1);
        if (em_from) begin
          em_addr <= em_addr_inc;
        end
      end

      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q    <= in_ch.data.operation;
      frame_q <= frame_wide[FW-1:0];
      n_q     <= n_sat;
    end
    // totals are final for the whole item by the time it emits
    if (issue) begin
      s1_from         <= em_from;
      s1_last         <= em_last;
      s1_tot.written  <= write_total;
      s1_tot.read     <= read_total;
      s1_tot.underrun <= underrun_total;
      s1_tot.overrun  <= overrun_total;
    end
  end

  // ---------------- frame store ----------------
  // Writes happen in plan and wipe cycles, never in the cycle of a read, so a
  // registered read cannot see a same-cycle write to its entry.
  assign ram_waddr = (state == oafr_pkg::S_WIPE) ? wipe_addr : write_slot;
  assign ram_wdata = (state == oafr_pkg::S_WIPE) ? '0 : frame_q;

  oafr_ram #(
    .WIDTH (FW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (em_addr),
    .rdata (ram_rdata)
  );

  oafr_mod #(.DW(TW), .CW(CW)) u_mod_w (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (write_total),
    .divisor   (eff_cap),
    .busy      (w_busy),
    .remainder (w_rem)
  );

  oafr_mod #(.DW(TW), .CW(CW)) u_mod_r (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (read_total),
    .divisor   (eff_cap),
    .busy      (r_busy),
    .remainder (r_rem)
  );

  // ---------------- result queue ----------------
  assign rd_wide = XW'(ram_rdata);

  always_comb begin
    push_item.sample_out_0    = s1_from ? rd_wide[oafr_pkg::SAMPLE_W-1:0] : '0;
    push_item.sample_out_1    = s1_from ? rd_wide[XW-1:oafr_pkg::SAMPLE_W] : '0;
    push_item.from_buffer     = s1_from;
    push_item.last_frame      = s1_last;
    push_item.written_frames  = s1_tot.written;
    push_item.read_frames     = s1_tot.read;
    push_item.underrun_events = s1_tot.underrun;
    push_item.overrun_frames  = s1_tot.overrun;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (s1_valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(s1_valid) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fifo[wr_ptr] <= push_item;
    end
  end

  assign out_ch.valid = count != '0;
  assign out_ch.data  = fifo[rd_ptr];

  // ---------------- checks ----------------
  a_pend_consistent: assert property (@(posedge clk) disable iff (rst)
    pend == write_total - read_total)
    else $error("unread count out of step with totals");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (count < 2'd2 || pop))
    else $error("result queue overflow");

  a_slots_in_range: assert property (@(posedge clk) disable iff (rst)
    state == oafr_pkg::S_IDLE |->
      (SW'(write_slot) < SW'(eff_cap) && SW'(read_slot) < SW'(eff_cap)))
    else $error("slot beyond capacity while idle");

  a_no_issue_after_last: assert property (@(posedge clk) disable iff (rst)
    (issue && em_last) |=> !issue)
    else $error("result issued after last result of an item");

endmodule

`default_nettype wire

>>> tb/tb_overwriting_audio_frame_ring.sv
// Self-checking bench for overwriting_audio_frame_ring: table-driven directed rows, then random
// phases at several capacities, each result checked against a predictor of the ring or hand-given totals.
// Depends on oafr_pkg, oafr_if and the block's RTL.

module tb_overwriting_audio_frame_ring;

  localparam int RING_DEPTH    = oafr_pkg::DEPTH_DEFAULT;
  localparam int MAX_BURST     = oafr_pkg::MAX_BURST_DEFAULT;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 49;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 20;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int REPORT_LIMIT  = 200;

  typedef enum bit {ROW_REQUEST, ROW_CAPACITY} row_kind_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOPPY} rx_mode_t;

  typedef struct {
    row_kind_t                  kind;
    logic [oafr_pkg::CAP_W-1:0] cap;
    oafr_pkg::in_item_t         req;
    bit                         typed;
    oafr_pkg::out_item_t        status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  oafr_in_if  in_ch();
  oafr_out_if out_ch();
  oafr_cfg_if cfg_ch();

  overwriting_audio_frame_ring DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  always #1 clk = ~clk;

  // ring predictor state
  logic [oafr_pkg::FRAME_W-1:0] ring_store  [RING_DEPTH];
  bit                           ring_filled [RING_DEPTH];
  logic [oafr_pkg::TOTAL_W-1:0] wr_total = '0;
  logic [oafr_pkg::TOTAL_W-1:0] rd_total = '0;
  logic [oafr_pkg::EVENT_W-1:0] under_total = '0;
  logic [oafr_pkg::EVENT_W-1:0] over_total = '0;
  logic [oafr_pkg::CAP_W-1:0]   cap_reg = oafr_pkg::CAP_RESET;

  oafr_pkg::out_item_t step_frames[$];
  oafr_pkg::out_item_t pending_frames[$];
  stim_row_t           stim_table[$];

  int unsigned burst_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned frames_checked = 0;
  int unsigned requests_sent = 0;
  int unsigned capacity_writes = 0;
  bit          long_hold_req = 1'b0;

  function automatic int unsigned ring_size();
    if (cap_reg == 0) return 1;
    if (cap_reg > RING_DEPTH) return RING_DEPTH;
    return cap_reg;
  endfunction

  // Frames a read or tap asks for, where its span starts and how much of it the ring holds.
  function automatic void burst_span(input oafr_pkg::in_item_t req, output int unsigned n,
                                     output logic [63:0] first, output int unsigned copy);
    logic [63:0] avail;
    int unsigned sz;
    sz = ring_size();
    n = (req.frame_count > MAX_BURST) ? MAX_BURST : req.frame_count;
    first = rd_total;
    if (req.operation == oafr_pkg::OP_READ) begin
      avail = wr_total - rd_total;
      // more unread than slots after a capacity cut: jump ahead, not an overrun
      if (avail > sz) begin
        avail = sz;
        first = wr_total - sz;
      end
    end else begin
      avail = (wr_total < sz) ? wr_total : sz;
    end
    copy = (avail < n) ? avail : n;
    if (req.operation == oafr_pkg::OP_TAP) first = wr_total - copy;
  endfunction

  function automatic bit touches_blank(input oafr_pkg::in_item_t req);
    int unsigned n, copy, sz;
    logic [63:0] first;
    if (req.operation != oafr_pkg::OP_READ && req.operation != oafr_pkg::OP_TAP) return 1'b0;
    burst_span(req, n, first, copy);
    sz = ring_size();
    for (int unsigned k = 0; k < copy; k++)
      if (!ring_filled[(first + k) % sz]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void ring_predict(input oafr_pkg::in_item_t req);
    int unsigned sz, n, copy, count;
    logic [63:0] first, slot;
    logic [oafr_pkg::FRAME_W-1:0] word;
    oafr_pkg::out_item_t res;
    sz = ring_size();
    count = 1;
    copy = 0;
    first = '0;
    step_frames.delete();
    if (req.operation == oafr_pkg::OP_WRITE) begin
      slot = wr_total % sz;
      ring_store[slot] = {req.sample_in_1, req.sample_in_0};
      ring_filled[slot] = 1'b1;
      wr_total = wr_total + 1;
      if (wr_total - rd_total > sz) begin
        over_total = over_total + oafr_pkg::EVENT_W'(wr_total - rd_total - sz);
        rd_total = wr_total - sz;
      end
    end else if (req.operation == oafr_pkg::OP_CLEAR) begin
      // a clear leaves every slot holding a defined zero frame
      for (int k = 0; k < RING_DEPTH; k++) begin
        ring_store[k] = '0;
        ring_filled[k] = 1'b1;
      end
      wr_total = '0;
      rd_total = '0;
      under_total = '0;
      over_total = '0;
    end else begin
      burst_span(req, n, first, copy);
      if (n != 0) begin
        if (copy < n) under_total = under_total + 1;
        if (req.operation == oafr_pkg::OP_READ) rd_total = first + copy;
        count = n;
      end
    end
    for (int unsigned k = 0; k < count; k++) begin
      res = '0;
      if (k < copy) begin
        word = ring_store[(first + k) % sz];
        res.sample_out_0 = word[oafr_pkg::SAMPLE_W-1:0];
        res.sample_out_1 = word[oafr_pkg::FRAME_W-1:oafr_pkg::SAMPLE_W];
        res.from_buffer  = 1'b1;
      end
      res.last_frame      = (k == count - 1);
      res.written_frames  = wr_total;
      res.read_frames     = rd_total;
      res.underrun_events = under_total;
      res.overrun_frames  = over_total;
      step_frames.push_back(res);
    end
  endfunction

  function automatic oafr_pkg::in_item_t random_request();
    oafr_pkg::in_item_t req;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 48)      req.operation = oafr_pkg::OP_WRITE;
    else if (pick < 72) req.operation = oafr_pkg::OP_READ;
    else if (pick < 94) req.operation = oafr_pkg::OP_TAP;
    else                req.operation = oafr_pkg::OP_CLEAR;
    req.sample_in_0 = $urandom;
    req.sample_in_1 = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 5)       req.frame_count = '0;
    else if (pick < 70) req.frame_count = oafr_pkg::FCOUNT_W'($urandom_range(1, 8));
    else if (pick < 92) req.frame_count = oafr_pkg::FCOUNT_W'($urandom_range(9, 64));
    else                req.frame_count = oafr_pkg::FCOUNT_W'($urandom_range(65, 127));
    // slots neither written nor cleared since reset hold nothing defined; store a frame instead
    if (touches_blank(req)) req.operation = oafr_pkg::OP_WRITE;
    return req;
  endfunction

  task automatic add_request(input oafr_pkg::op_t op, input logic [31:0] s0,
                             input logic [31:0] s1,
                             input logic [oafr_pkg::FCOUNT_W-1:0] cnt);
    stim_row_t row;
    row.kind = ROW_REQUEST;
    row.cap = '0;
    row.req.operation = op;
    row.req.sample_in_0 = s0;
    row.req.sample_in_1 = s1;
    row.req.frame_count = cnt;
    row.typed = 1'b0;
    row.status = '0;
    stim_table.push_back(row);
  endtask

  // single status result whose totals are known by hand
  task automatic add_status(input oafr_pkg::op_t op, input logic [31:0] s0,
                            input logic [31:0] s1,
                            input logic [oafr_pkg::FCOUNT_W-1:0] cnt, input logic [63:0] w,
                            input logic [63:0] r, input logic [31:0] u, input logic [31:0] o);
    add_request(op, s0, s1, cnt);
    stim_table[$].typed = 1'b1;
    stim_table[$].status.last_frame = 1'b1;
    stim_table[$].status.written_frames = w;
    stim_table[$].status.read_frames = r;
    stim_table[$].status.underrun_events = u;
    stim_table[$].status.overrun_frames = o;
  endtask

  task automatic add_capacity(input logic [oafr_pkg::CAP_W-1:0] value);
    stim_row_t row;
    row.kind = ROW_CAPACITY;
    row.cap = value;
    row.req = '0;
    row.typed = 1'b0;
    row.status = '0;
    stim_table.push_back(row);
  endtask

  task automatic offer_request(input oafr_pkg::in_item_t req, input bit typed,
                               input oafr_pkg::out_item_t status);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= req;
    do @(posedge clk); while (!in_ch.ready);
    ring_predict(req);
    if (typed) pending_frames.push_back(status);
    else foreach (step_frames[k]) pending_frames.push_back(step_frames[k]);
    requests_sent++;
  endtask

  task automatic write_capacity(input logic [oafr_pkg::CAP_W-1:0] value);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cap_reg = value;
    capacity_writes++;
  endtask

  task automatic compare_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("t=%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    oafr_pkg::out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("t=%0t: unexpected result: expected none, actual %0h", $time, out_ch.data);
      end else begin
        want = pending_frames.pop_front();
        compare_field("sample_out_0", want.sample_out_0, out_ch.data.sample_out_0);
        compare_field("sample_out_1", want.sample_out_1, out_ch.data.sample_out_1);
        compare_field("from_buffer", want.from_buffer, out_ch.data.from_buffer);
        compare_field("last_frame", want.last_frame, out_ch.data.last_frame);
        compare_field("written_frames", want.written_frames, out_ch.data.written_frames);
        compare_field("read_frames", want.read_frames, out_ch.data.read_frames);
        compare_field("underrun_events", want.underrun_events, out_ch.data.underrun_events);
        compare_field("overrun_frames", want.overrun_frames, out_ch.data.overrun_frames);
        frames_checked++;
      end
    end
  end

  // result sink: stall pattern picked at random and changed at random intervals, plus one long hold-off
  initial begin
    rx_mode_t mode;
    int unsigned mode_left;
    bit chop, held;
    mode = RX_OPEN;
    mode_left = 0;
    chop = 1'b0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      chop = ~chop;
      case (mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   out_ch.ready <= chop;
      endcase
    end
  end

  initial begin
    int unsigned watch_cycles;
    for (watch_cycles = 0; watch_cycles < CYCLE_LIMIT; watch_cycles++) @(posedge clk);
    $display("Timeout after %0d cycles, %0d results still pending",
             CYCLE_LIMIT, pending_frames.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned phase, item;
    logic [oafr_pkg::CAP_W-1:0] cap_value;
    oafr_pkg::in_item_t req;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;

    // directed rows, starting from reset capacity
    add_request(oafr_pkg::OP_READ, 32'h0, 32'h0, 7'd3);              // empty: all silence
    add_status(oafr_pkg::OP_TAP, 32'h0, 32'h0, 7'd0,
               64'd0, 64'd0, 32'd1, 32'd0);                          // zero count
    add_status(oafr_pkg::OP_WRITE, 32'h0, 32'h0, 7'd1, 64'd1, 64'd0, 32'd1, 32'd0);
    add_status(oafr_pkg::OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127,
               64'd2, 64'd0, 32'd1, 32'd0);
    add_status(oafr_pkg::OP_WRITE, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 7'd0,
               64'd3, 64'd0, 32'd1, 32'd0);
    add_request(oafr_pkg::OP_TAP, 32'h0, 32'h0, 7'd2);
    add_request(oafr_pkg::OP_READ, 32'h0, 32'h0, 7'd127);            // saturates, short
    add_status(oafr_pkg::OP_READ, 32'h0, 32'h0, 7'd0, 64'd3, 64'd3, 32'd2, 32'd0);
    add_status(oafr_pkg::OP_CLEAR, 32'h0, 32'h0, 7'd5, 64'd0, 64'd0, 32'd0, 32'd0);
    add_capacity(11'd0);                                             // acts as one slot
    add_status(oafr_pkg::OP_WRITE, 32'h1111_1111, 32'h2222_2222, 7'd1,
               64'd1, 64'd0, 32'd0, 32'd0);
    add_status(oafr_pkg::OP_WRITE, 32'h3333_3333, 32'h4444_4444, 7'd1,
               64'd2, 64'd1, 32'd0, 32'd1);
    add_request(oafr_pkg::OP_READ, 32'h0, 32'h0, 7'd1);
    add_request(oafr_pkg::OP_TAP, 32'h0, 32'h0, 7'd65);
    add_capacity(11'd3);
    add_status(oafr_pkg::OP_CLEAR, 32'h0, 32'h0, 7'd0, 64'd0, 64'd0, 32'd0, 32'd0);
    add_status(oafr_pkg::OP_WRITE, 32'h0000_0001, 32'h8000_0000, 7'd1,
               64'd1, 64'd0, 32'd0, 32'd0);
    add_status(oafr_pkg::OP_WRITE, 32'h0000_0002, 32'h4000_0000, 7'd1,
               64'd2, 64'd0, 32'd0, 32'd0);
    add_status(oafr_pkg::OP_WRITE, 32'h0000_0003, 32'h2000_0000, 7'd1,
               64'd3, 64'd0, 32'd0, 32'd0);
    add_status(oafr_pkg::OP_WRITE, 32'h0000_0004, 32'h1000_0000, 7'd1,
               64'd4, 64'd1, 32'd0, 32'd1);
    add_capacity(11'd1);                                             // read falls behind
    add_request(oafr_pkg::OP_READ, 32'h0, 32'h0, 7'd2);
    add_capacity(11'd2047);                                          // clamps to depth
    add_status(oafr_pkg::OP_CLEAR, 32'h0, 32'h0, 7'd0, 64'd0, 64'd0, 32'd0, 32'd0);
    add_request(oafr_pkg::OP_TAP, 32'h0, 32'h0, 7'd64);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < stim_table.size(); k++) begin
      if (stim_table[k].kind == ROW_CAPACITY) write_capacity(stim_table[k].cap);
      else offer_request(stim_table[k].req, stim_table[k].typed, stim_table[k].status);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       cap_value = 11'd4;
        1:       cap_value = 11'd1;
        2:       cap_value = 11'd2047;
        3:       cap_value = oafr_pkg::CAP_W'($urandom_range(2, 16));
        4:       cap_value = oafr_pkg::CAP_W'($urandom_range(17, 200));
        5:       cap_value = 11'd0;
        6:       cap_value = 11'd1024;
        default: cap_value = oafr_pkg::CAP_W'($urandom_range(1, 2047));
      endcase
      write_capacity(cap_value);
      if (phase == 1) long_hold_req = 1'b1;
      if ($urandom_range(0, 1) == 1) begin
        req = '0;
        req.operation = oafr_pkg::OP_CLEAR;
        offer_request(req, 1'b0, '0);
      end
      for (item = 0; item < PHASE_ITEMS; item++) offer_request(random_request(), 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests over %0d capacity settings, checked %0d result frames",
             requests_sent, capacity_writes, frames_checked);
    $display("Final ring totals: written %0d, read %0d, underruns %0d, overruns %0d",
             wr_total, rd_total, under_total, over_total);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
